### rtl/plr_pkg.sv
`timescale 1ns / 1ps

package plr_pkg;

  // fixed field widths of the page and result words
  localparam int PAGE_W      = 4;
  localparam int FRAME_OUT_W = 3;
  localparam int COUNT_W     = 16;

  // default table size
  localparam int FRAMES_DEF  = 8;

  // sequencer states of the back end
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD
  } state_t;

  // one request word between the input queue and the back end
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } req_t;

  // one result word
  typedef struct packed {
    logic                   page_fault;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
    logic [COUNT_W-1:0]     fault_total;
  } result_t;

endpackage

### rtl/plr_queue.sv
`timescale 1ns / 1ps

module plr_queue #(
  parameter int W = plr_pkg::PAGE_W
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import plr_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         do_push;
  logic         do_pop;

  // handshake qualification
  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and fill count next values
  always_comb begin
    wptr_nxt  = do_push ? ~wptr_r : wptr_r;
    rptr_nxt  = do_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

### rtl/plr_back.sv
`timescale 1ns / 1ps

module plr_back #(
  parameter int FRAMES = plr_pkg::FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             policy,
  input  plr_pkg::req_t    req,
  output logic             req_pop,
  input  logic             res_full,
  output logic             res_push,
  output plr_pkg::result_t res
);
  import plr_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam int RW = $clog2(FRAMES);
  localparam logic [FW-1:0] LAST = FW'(FRAMES - 1);

  // frame table
  logic [PAGE_W-1:0]  page_mem_r [FRAMES];
  logic [FRAMES-1:0]  valid_r;
  logic [RW-1:0]      rank_r [FRAMES];
  logic [FW-1:0]      fptr_r;
  logic [COUNT_W-1:0] cnt_r;

  // sequencer and scan results
  state_t             state_r, state_nxt;
  logic [FW-1:0]      idx_r;
  logic [PAGE_W-1:0]  page_r;
  logic               hit_r;
  logic [FW-1:0]      hit_f_r;
  logic [RW-1:0]      hit_rk_r;
  logic               emp_r;
  logic [FW-1:0]      emp_f_r;
  logic [RW-1:0]      best_rk_r;
  logic [FW-1:0]      best_f_r;
  logic [PAGE_W-1:0]  best_pg_r;
  logic [RW-1:0]      fifo_rk_r;
  logic [PAGE_W-1:0]  fifo_pg_r;

  logic               cur_v;
  logic [PAGE_W-1:0]  cur_pg;
  logic [RW-1:0]      cur_rk;

  logic [FW-1:0]      sel_f;
  logic [RW-1:0]      sel_old;
  logic [PAGE_W-1:0]  sel_pg;
  logic               ev_valid;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [FW-1:0]      fptr_nxt;
  logic [FW+FRAME_OUT_W-1:0] frame_ext;

  // frame under the scan index
  assign cur_v  = valid_r[idx_r];
  assign cur_pg = page_mem_r[idx_r];
  assign cur_rk = rank_r[idx_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.valid && !res_full) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == LAST) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    req_pop  = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      ST_IDLE: req_pop  = req.valid && !res_full;
      ST_SCAN: req_pop  = 1'b0;
      ST_UPD:  res_push = 1'b1;
      default: req_pop  = 1'b0;
    endcase
  end

  // target frame: hit, lowest empty, or victim by policy
  always_comb begin
    sel_f   = fptr_r;
    sel_old = fifo_rk_r;
    sel_pg  = fifo_pg_r;
    priority if (hit_r) begin
      sel_f   = hit_f_r;
      sel_old = hit_rk_r;
    end else if (emp_r) begin
      sel_f   = emp_f_r;
    end else if (policy) begin
      sel_f   = best_f_r;
      sel_old = best_rk_r;
      sel_pg  = best_pg_r;
    end else begin
      sel_f   = fptr_r;
    end
  end

  assign ev_valid  = !hit_r && !emp_r;
  assign cnt_nxt   = (cnt_r != '1) ? cnt_r + COUNT_W'(1) : cnt_r;
  assign fptr_nxt  = (sel_f == LAST) ? '0 : sel_f + FW'(1);
  assign frame_ext = {{FRAME_OUT_W{1'b0}}, sel_f};

  // result word
  always_comb begin
    res.page_fault    = !hit_r;
    res.frame_index   = frame_ext[FRAME_OUT_W-1:0];
    res.evicted_valid = ev_valid;
    res.evicted_page  = ev_valid ? sel_pg : '0;
    res.fault_total   = hit_r ? cnt_r : cnt_nxt;
  end

  // sequencer and scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      emp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (req_pop) begin
        idx_r <= '0;
        hit_r <= 1'b0;
        emp_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        idx_r <= (idx_r == LAST) ? '0 : idx_r + FW'(1);
        if (cur_v && cur_pg == page_r && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!cur_v && !emp_r) begin
          emp_r <= 1'b1;
        end
      end
    end
  end

  // scan payload captures
  always_ff @(posedge clk) begin
    if (req_pop) begin
      page_r <= req.page;
    end
    if (state_r == ST_SCAN) begin
      if (cur_v && cur_pg == page_r && !hit_r) begin
        hit_f_r  <= idx_r;
        hit_rk_r <= cur_rk;
      end
      if (!cur_v && !emp_r) begin
        emp_f_r <= idx_r;
      end
      if (idx_r == '0 || cur_rk > best_rk_r) begin
        best_rk_r <= cur_rk;
        best_f_r  <= idx_r;
        best_pg_r <= cur_pg;
      end
      if (idx_r == fptr_r) begin
        fifo_rk_r <= cur_rk;
        fifo_pg_r <= cur_pg;
      end
    end
  end

  // table update: valid marks, ranks, pointer, fault count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fptr_r  <= '0;
      cnt_r   <= '0;
      for (int g = 0; g < FRAMES; g++) begin
        rank_r[g] <= '0;
      end
    end else if (state_r == ST_UPD) begin
      for (int g = 0; g < FRAMES; g++) begin
        if (FW'(g) == sel_f) begin
          rank_r[g] <= '0;
        end else if (valid_r[g] && ((!hit_r && emp_r) || rank_r[g] < sel_old)) begin
          rank_r[g] <= rank_r[g] + RW'(1);
        end
      end
      if (!hit_r) begin
        valid_r[sel_f] <= 1'b1;
        fptr_r         <= fptr_nxt;
        cnt_r          <= cnt_nxt;
      end
    end
  end

  // page store, no reset
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && !hit_r) begin
      page_mem_r[sel_f] <= page_r;
    end
  end

  // result space was checked before the scan started
  a_upd_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> !res_full)
    else $error("result queue full at update");

  // a hit always names a valid frame
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && hit_r) |-> valid_r[hit_f_r])
    else $error("hit on an empty frame");

  // fault count never goes down
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r >= $past(cnt_r))
    else $error("fault count decreased");

  // scan restarts at frame zero on every new word
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("scan did not start at frame zero");

endmodule

### rtl/page_replacement_fifo_lru.sv
`timescale 1ns / 1ps
// Page replacement table, FIFO or least recently used.
// Input channel: drive in_page_number and raise in_push; the word is taken
// at a clock edge with in_push high and in_full low. A two-word input queue
// sits in front of the table.
// Result channel: while out_empty is low the oldest result is on the out_
// ports; raise out_pop to take it. A two-word result queue decouples the
// table from the receiver, so a stalled receiver only stops the block once
// both result words are waiting.
// Config channel: cfg_ready is always high; bit cfg_data selects the policy
// (0 round robin, 1 least recently used). Write it only while idle.
// Timing: the table sequencer takes a word in its idle state, scans all
// FRAMES frames (one frame per cycle for hit, empty and victim) and then
// updates the table in its update state; the next word is taken after that.
// Reset (rst_n low, synchronous) empties both queues, marks all frames
// empty, clears ranks, the round-robin pointer, the fault count and selects
// round robin. No clearing pass is needed.

module page_replacement_fifo_lru #(
  parameter int FRAMES = plr_pkg::FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic [plr_pkg::PAGE_W-1:0]        in_page_number,
  output logic                              in_full,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_page_fault,
  output logic [plr_pkg::FRAME_OUT_W-1:0]   out_frame_index,
  output logic                              out_evicted_valid,
  output logic [plr_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic [plr_pkg::COUNT_W-1:0]       out_fault_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data
);
  import plr_pkg::*;

  localparam int RES_W = $bits(result_t);

  logic              policy_r;
  logic              iq_empty;
  logic [PAGE_W-1:0] iq_page;
  req_t              req;
  logic              req_pop;
  logic              res_full;
  logic              res_push;
  result_t           res;
  result_t           res_q;
  logic [RES_W-1:0]  res_q_bits;

  // policy register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      policy_r <= cfg_data;
    end
  end

  // input queue
  plr_queue #(
    .W (PAGE_W)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (in_page_number),
    .full  (in_full),
    .pop   (req_pop),
    .rdata (iq_page),
    .empty (iq_empty)
  );

  assign req.valid = !iq_empty;
  assign req.page  = iq_page;

  // table sequencer
  plr_back #(
    .FRAMES (FRAMES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .policy   (policy_r),
    .req      (req),
    .req_pop  (req_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue
  plr_queue #(
    .W (RES_W)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q_bits),
    .empty (out_empty)
  );

  assign res_q             = res_q_bits;
  assign out_page_fault    = res_q.page_fault;
  assign out_frame_index   = res_q.frame_index;
  assign out_evicted_valid = res_q.evicted_valid;
  assign out_evicted_page  = res_q.evicted_page;
  assign out_fault_total   = res_q.fault_total;

endmodule
